/* hw/rtl/bilateral_image_filter_defines.svh */
// Assertion macros shared by the checker of the bilateral image filter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BILATERAL_IMAGE_FILTER_DEFINES_SVH
`define BILATERAL_IMAGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BIF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bilateral filter check failed");

// Next-cycle implication, disabled while reset is low.
`define BIF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bilateral filter check failed");

// Next-cycle implication that is checked during reset as well.
`define BIF_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bilateral filter check failed");

`endif

/* hw/rtl/bif_pkg.sv */
// Shared types and constants of the bilateral image filter.
// Depends on nothing; imported by the top level, bif_tables and bif_divider.
package bif_pkg;

    localparam int WEIGHT_FRAC_BITS = 16;  // fraction bits of a stored weight
    localparam int TW          = 17;   // stored weight width, Q1.16
    localparam int PIX_W       = 8;
    localparam int QW          = 8;    // quotient bits of one channel
    localparam int COLOR_DEPTH = 768;
    localparam int CIW         = 10;   // color index width
    localparam int OP_W        = 2;
    localparam int POS_W       = 10;

    localparam logic [OP_W-1:0] OP_COLOR  = 2'd0;
    localparam logic [OP_W-1:0] OP_SPACE  = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int RAD_W      = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BGR    = 2'd3;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_WT_LSB   = 10;
    localparam int IN_B_LSB    = 27;
    localparam int IN_G_LSB    = 35;
    localparam int IN_R_LSB    = 43;
    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic             color_we;
        logic             space_we;
        logic [CIW-1:0]   index;
        logic [TW-1:0]    weight;
    } t_tbl_wr;

endpackage

/* hw/rtl/bilateral_image_filter.sv */
// Bilateral image filter top level: line store, tap sequencer and accumulator.
// Depends on bif_pkg, bif_tables and bif_divider.
// Usage: configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data while idle;
// any write restarts the frame position. Slave beats carry table loads
// (tuser 0 color, 1 space) or padded pixels (tuser 2) in raster order. A load
// leaves s_tready high. A pixel that completes a window of side s = 2r+1 is
// read back from the line store as s*s taps, one tap a cycle through the
// weight and multiply-accumulate pipeline, then divided per channel by a
// shared bit-serial divider (one channel in gray; no division when the weight
// total is zero). s_tready stays low from that pixel beat until its result is
// loaded; other beats leave s_tready high. The result waits in an output register;
// a stalled master side holds the next result back and the block after it.
// Reset clears the position counters and the output valid and sets the
// configuration to width 1024, height 1024, radius 1 and gray; table and
// line store contents are undefined until written.
module bilateral_image_filter #(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_HEIGHT       = 1024,
    parameter int MAX_RADIUS       = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bif_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bif_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // table_index, table_weight, pixel_b, pixel_g, pixel_r, zero fill
    input  logic [bif_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // operation
    input  logic [bif_pkg::OP_W-1:0]           i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_b, out_g, out_r, out_row, out_col, zero fill
    output logic [bif_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // zero_weight
    output logic [0:0]                         o_m_tuser
);
    import bif_pkg::*;

    localparam int SLOTS  = 2 * MAX_RADIUS + 1;
    localparam int SD     = SLOTS * SLOTS;
    localparam int SW     = $clog2(SLOTS);
    localparam int SIW    = $clog2(SD);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int RDW    = $clog2(MAX_RADIUS + 1);
    localparam int LDEPTH = SLOTS * MAX_WIDTH;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int WCW    = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int HCW    = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;
    localparam int RCW    = (RDW > RAD_W) ? RDW : RAD_W;
    localparam int CMPW   = ((RW > CW) ? RW : CW) + 2;
    localparam int WW     = 2 * TW - WEIGHT_FRAC_BITS;
    localparam int SUMW   = WW + PIX_W + SIW;
    localparam int PXW    = 3 * PIX_W;

    localparam logic [1:0] CH_B = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_R = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CENTER = 8'b0000_0010,
        S_CLATCH = 8'b0000_0100,
        S_TAPS   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DWAIT  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state               r_state;
    logic [CFG_DATA_W-1:0] r_cfg_width;
    logic [CFG_DATA_W-1:0] r_cfg_height;
    logic [RAD_W-1:0]     r_cfg_radius;
    logic                 r_cfg_bgr;
    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic [SW-1:0]        r_slot;
    logic                 r_p1, r_p2, r_p3;
    logic [1:0]           r_ch;
    logic                 r_out_valid;

    // Input beat fields.
    logic [OP_W-1:0]  in_op;
    logic [CIW-1:0]   in_idx;
    logic [TW-1:0]    in_wt;
    logic [PIX_W-1:0] in_b, in_g, in_r;
    logic             acc, acc_pix;

    assign in_op   = i_s_tuser;
    assign in_idx  = i_s_tdata[IN_IDX_LSB +: CIW];
    assign in_wt   = i_s_tdata[IN_WT_LSB +: TW];
    assign in_b    = i_s_tdata[IN_B_LSB +: PIX_W];
    assign in_g    = i_s_tdata[IN_G_LSB +: PIX_W];
    assign in_r    = i_s_tdata[IN_R_LSB +: PIX_W];
    assign o_s_tready = (r_state == S_IDLE);
    assign acc     = i_s_tvalid && o_s_tready;
    assign acc_pix = acc && (in_op == OP_PIXEL);

    // Effective geometry.
    logic [WCW-1:0] wq, w_eff;
    logic [HCW-1:0] hq, h_eff;
    logic [RCW-1:0] rq;
    logic [RDW-1:0] r_eff;
    always_comb begin
        wq = WCW'(r_cfg_width);
        if (wq == '0) w_eff = WCW'(1);
        else if (wq > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
        else w_eff = wq;
        hq = HCW'(r_cfg_height);
        if (hq == '0) h_eff = HCW'(1);
        else if (hq > HCW'(MAX_HEIGHT)) h_eff = HCW'(MAX_HEIGHT);
        else h_eff = hq;
        rq = RCW'(r_cfg_radius);
        if (rq == '0) r_eff = RDW'(1);
        else if (rq > RCW'(MAX_RADIUS)) r_eff = RDW'(MAX_RADIUS);
        else r_eff = RDW'(rq);
    end

    logic [CMPW-1:0] row_c, col_c, r_c, r2_c;
    logic            produce, col_last, row_last;
    logic [SW:0]     slot_x, rr, rr2, ss_x, cs_x;
    assign row_c    = CMPW'(r_row);
    assign col_c    = CMPW'(r_col);
    assign r_c      = CMPW'(r_eff);
    assign r2_c     = r_c + r_c;
    assign produce  = (row_c >= r2_c) && (col_c >= r2_c);
    assign col_last = (WCW'(r_col) + WCW'(1)) >= w_eff;
    assign row_last = (HCW'(r_row) + HCW'(1)) >= h_eff;
    assign slot_x   = (SW+1)'(r_slot);
    assign rr       = (SW+1)'(r_eff);
    assign rr2      = rr + rr;
    // Ring slots of the window top row and of the center row.
    assign ss_x = (slot_x >= rr2) ? slot_x - rr2 : slot_x + (SW+1)'(SLOTS) - rr2;
    assign cs_x = (slot_x >= rr)  ? slot_x - rr  : slot_x + (SW+1)'(SLOTS) - rr;

    // Tap sequencing registers.
    logic [SW-1:0]    r_cslot, r_tslot, r_side, r_ti, r_tj;
    logic [CW-1:0]    r_ccol, r_tcol, r_tcol0;
    logic [SIW-1:0]   r_si, r_si1;
    logic [POS_W-1:0] r_orow, r_ocol;

    // Line store: the last SLOTS padded rows, {r, g, b}.
    logic [PXW-1:0] mem_line [LDEPTH];
    logic [PXW-1:0] r_line_q;
    logic [LAW-1:0] waddr, raddr;
    logic [PXW-1:0] wdata;
    assign waddr = LAW'(r_slot) * LAW'(MAX_WIDTH) + LAW'(r_col);
    assign wdata = r_cfg_bgr ? {in_r, in_g, in_b} : {{(2*PIX_W){1'b0}}, in_b};
    assign raddr = (r_state == S_CENTER)
                 ? LAW'(r_cslot) * LAW'(MAX_WIDTH) + LAW'(r_ccol)
                 : LAW'(r_tslot) * LAW'(MAX_WIDTH) + LAW'(r_tcol);

    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            mem_line[waddr] <= wdata;
        end
        r_line_q <= mem_line[raddr];
    end

    // Stage 1: color index from the tap and the center pixel.
    logic [PXW-1:0]   r_center;
    logic [PIX_W-1:0] db, dg, dr;
    logic [CIW-1:0]   ci;
    always_comb begin
        db = (r_line_q[7:0] > r_center[7:0]) ? r_line_q[7:0] - r_center[7:0]
                                             : r_center[7:0] - r_line_q[7:0];
        dg = (r_line_q[15:8] > r_center[15:8]) ? r_line_q[15:8] - r_center[15:8]
                                               : r_center[15:8] - r_line_q[15:8];
        dr = (r_line_q[23:16] > r_center[23:16]) ? r_line_q[23:16] - r_center[23:16]
                                                 : r_center[23:16] - r_line_q[23:16];
        ci = CIW'(db);
        if (r_cfg_bgr) begin
            ci = ci + CIW'(dg) + CIW'(dr);
        end
    end

    t_tbl_wr       tbl_wr;
    logic [TW-1:0] color_w, space_w;
    assign tbl_wr.color_we = acc && (in_op == OP_COLOR);
    assign tbl_wr.space_we = acc && (in_op == OP_SPACE);
    assign tbl_wr.index    = in_idx;
    assign tbl_wr.weight   = in_wt;

    bif_tables #(.MAX_RADIUS(MAX_RADIUS)) u_tables (
        .i_clk        (i_clk),
        .i_wr         (tbl_wr),
        .i_color_addr (ci),
        .i_space_addr (r_si1),
        .o_color      (color_w),
        .o_space      (space_w)
    );

    // Stages 2 and 3: tap weight, then weighted accumulation.
    logic [PXW-1:0]      r_pix2, r_pix3;
    logic [2*TW-1:0]     r_prod;
    logic [WW-1:0]       w;
    logic [WW+PIX_W-1:0] wb, wg, wr;
    logic [SUMW-1:0]     r_sb, r_sg, r_sr, r_ws;
    assign w  = WW'(r_prod >> WEIGHT_FRAC_BITS);
    assign wb = w * r_pix3[7:0];
    assign wg = w * r_pix3[15:8];
    assign wr = w * r_pix3[23:16];

    // Divider, shared by the three channels.
    logic            div_start, div_done;
    logic [SUMW-1:0] div_num;
    logic [QW-1:0]   div_q;
    assign div_start = (r_state == S_DSTART);
    always_comb begin
        case (r_ch)
            CH_G:    div_num = r_sg;
            CH_R:    div_num = r_sr;
            default: div_num = r_sb;
        endcase
    end

    bif_divider #(.SUMW(SUMW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_ws),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    logic             taps_done, pipe_empty, out_load;
    assign taps_done  = (r_ti == r_side - SW'(1)) && (r_tj == r_side - SW'(1));
    assign pipe_empty = !r_p1 && !r_p2 && !r_p3;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= CFG_DATA_W'(1024);
            r_cfg_height <= CFG_DATA_W'(1024);
            r_cfg_radius <= RAD_W'(1);
            r_cfg_bgr    <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_slot       <= '0;
            r_p1         <= 1'b0;
            r_p2         <= 1'b0;
            r_p3         <= 1'b0;
            r_ch         <= CH_B;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_cfg_width  <= i_cfg_data;
                    REG_HEIGHT: r_cfg_height <= i_cfg_data;
                    REG_RADIUS: r_cfg_radius <= i_cfg_data[RAD_W-1:0];
                    REG_BGR:    r_cfg_bgr    <= i_cfg_data[0];
                    default: ;
                endcase
                r_row  <= '0;
                r_col  <= '0;
                r_slot <= '0;
            end else if (acc_pix) begin
                if (col_last) begin
                    r_col <= '0;
                    if (row_last) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_slot <= (r_slot == SW'(SLOTS - 1)) ? '0 : r_slot + SW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end

            r_p1 <= (r_state == S_TAPS);
            r_p2 <= r_p1;
            r_p3 <= r_p2;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (acc_pix && produce) r_state <= S_CENTER;
                end
                S_CENTER: r_state <= S_CLATCH;
                S_CLATCH: r_state <= S_TAPS;
                S_TAPS: begin
                    if (taps_done) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (pipe_empty) begin
                        r_ch    <= CH_B;
                        r_state <= (r_ws == '0) ? S_OUT : S_DSTART;
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        if ((r_ch == CH_R) || !r_cfg_bgr) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    logic [PIX_W-1:0] r_qb, r_qg, r_qr;
    logic             r_zw;
    logic [PIX_W-1:0] r_ob, r_og, r_or;
    logic [POS_W-1:0] r_orow_o, r_ocol_o;
    logic             r_ozw;

    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            r_cslot <= SW'(cs_x);
            r_tslot <= SW'(ss_x);
            r_ccol  <= CW'(col_c - r_c);
            r_tcol  <= CW'(col_c - r2_c);
            r_tcol0 <= CW'(col_c - r2_c);
            r_side  <= SW'(rr2 + (SW+1)'(1));
            r_orow  <= POS_W'(row_c - r2_c);
            r_ocol  <= POS_W'(col_c - r2_c);
            r_ti    <= '0;
            r_tj    <= '0;
            r_si    <= '0;
        end
        if (r_state == S_CLATCH) begin
            r_center <= r_line_q;
            r_sb     <= '0;
            r_sg     <= '0;
            r_sr     <= '0;
            r_ws     <= '0;
        end
        if (r_state == S_TAPS) begin
            r_si <= r_si + SIW'(1);
            if (r_tj == r_side - SW'(1)) begin
                r_tj    <= '0;
                r_tcol  <= r_tcol0;
                r_ti    <= r_ti + SW'(1);
                r_tslot <= (r_tslot == SW'(SLOTS - 1)) ? '0 : r_tslot + SW'(1);
            end else begin
                r_tj   <= r_tj + SW'(1);
                r_tcol <= r_tcol + CW'(1);
            end
        end
        r_si1  <= r_si;
        r_pix2 <= r_line_q;
        r_prod <= (2*TW)'(color_w) * (2*TW)'(space_w);
        r_pix3 <= r_pix2;
        if (r_p3) begin
            r_sb <= r_sb + SUMW'(wb);
            r_sg <= r_sg + SUMW'(wg);
            r_sr <= r_sr + SUMW'(wr);
            r_ws <= r_ws + SUMW'(w);
        end
        if ((r_state == S_DRAIN) && pipe_empty) begin
            r_qb <= '0;
            r_qg <= '0;
            r_qr <= '0;
            r_zw <= (r_ws == '0);
        end
        if ((r_state == S_DWAIT) && div_done) begin
            case (r_ch)
                CH_G:    r_qg <= div_q;
                CH_R:    r_qr <= div_q;
                default: r_qb <= div_q;
            endcase
        end
        if (out_load) begin
            r_ob     <= r_qb;
            r_og     <= r_qg;
            r_or     <= r_qr;
            r_orow_o <= r_orow;
            r_ocol_o <= r_ocol;
            r_ozw    <= r_zw;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_ocol_o, r_orow_o, r_or, r_og, r_ob};
    assign o_m_tuser  = r_ozw;

endmodule

/* hw/rtl/bif_tables.sv */
// Color-weight and space-weight tables of the bilateral filter.
// Depends on bif_pkg; one write port and one registered read port each.
module bif_tables #(
    parameter int MAX_RADIUS = 4
) (
    input  logic                                     i_clk,
    input  bif_pkg::t_tbl_wr                         i_wr,
    input  logic [bif_pkg::CIW-1:0]                  i_color_addr,
    input  logic [$clog2((2*MAX_RADIUS+1)**2)-1:0]   i_space_addr,
    output logic [bif_pkg::TW-1:0]                   o_color,
    output logic [bif_pkg::TW-1:0]                   o_space
);
    import bif_pkg::*;

    localparam int SD  = (2*MAX_RADIUS+1) * (2*MAX_RADIUS+1);
    localparam int SIW = $clog2(SD);

    logic [TW-1:0] mem_color [COLOR_DEPTH];
    logic [TW-1:0] mem_space [SD];
    logic [TW-1:0] r_color_q;
    logic [TW-1:0] r_space_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.color_we && (i_wr.index < CIW'(COLOR_DEPTH))) begin
            mem_color[i_wr.index] <= i_wr.weight;
        end
        r_color_q <= mem_color[i_color_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.space_we && (i_wr.index < CIW'(SD))) begin
            mem_space[i_wr.index[SIW-1:0]] <= i_wr.weight;
        end
        r_space_q <= mem_space[i_space_addr];
    end

    assign o_color = r_color_q;
    assign o_space = r_space_q;

endmodule

/* hw/rtl/bif_divider.sv */
// Iterative rounding divider: quotient of (2*num + den) / (2*den), one bit a cycle.
// Depends on bif_pkg; the quotient is known to fit in QW bits.
module bif_divider #(
    parameter int SUMW = 33
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SUMW-1:0]         i_num,
    input  logic [SUMW-1:0]         i_den,
    output logic                    o_done,
    output logic [bif_pkg::QW-1:0]  o_quot
);
    import bif_pkg::*;

    localparam int NW = SUMW + 2;
    localparam int DW = NW + QW - 1;
    localparam int KW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_dsh;
    logic [QW-1:0] r_quot;
    logic          fits;

    assign fits = DW'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= '0;
                r_rem  <= NW'({i_num, 1'b0}) + NW'(i_den);
                r_dsh  <= DW'({i_den, 1'b0}) << (QW - 1);
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= r_rem - NW'(r_dsh);
                end
                r_quot <= {r_quot[QW-2:0], fits};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt + KW'(1);
                if (r_cnt == KW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/bif_checker.sv */
// Port-level checker of the bilateral image filter, bound to the top level.
// Depends on bilateral_image_filter_defines.svh for the assertion macros.
`include "bilateral_image_filter_defines.svh"

module bif_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    // The output register is empty right after reset.
    `BIF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid)

    // A stalled result beat stays put.
    `BIF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // A zero weight total forces every channel to zero.
    `BIF_ASSERT_SAME(a_zero_weight, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[23:0] == 24'd0)

    // A new result is loaded only at the end of a busy pixel.
    `BIF_ASSERT_SAME(a_load_busy, i_clk, i_rst_n, $rose(o_m_tvalid), !$past(i_s_tready))

endmodule

bind bilateral_image_filter bif_checker u_bif_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
